/* src/pfa_pkg.sv */
`timescale 1ns / 1ps

package pfa_pkg;

    // Default sizes of the frame pool
    localparam int NUM_PAGES_DEF = 128;
    localparam int MAX_ALLOC_DEF = 64;

    localparam int FRAME_W = 7;
    localparam int COUNT_W = 7;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic               opcode;
        logic [COUNT_W-1:0] page_count;
        logic [FRAME_W-1:0] chain_head;
        logic               chain_present;
    } cmd_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_index;
        logic               last;
        logic [1:0]         status;
    } result_t;

    // Word handed from the sequencer to the output register
    typedef struct packed {
        logic    valid;
        result_t word;
    } emit_t;

endpackage

/* src/pfa_ram.sv */
`timescale 1ns / 1ps

module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* src/pfa_seq.sv */
`timescale 1ns / 1ps

module pfa_seq #(
    parameter int NUM_PAGES = pfa_pkg::NUM_PAGES_DEF,
    parameter int MAX_ALLOC = pfa_pkg::MAX_ALLOC_DEF,
    localparam int PAGE_W = $clog2(NUM_PAGES),
    localparam int LINK_W = PAGE_W + 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  pfa_pkg::cmd_t       cmd,
    output logic                busy,
    output logic                ram_we,
    output logic [PAGE_W-1:0]   ram_addr,
    output logic [LINK_W-1:0]   ram_wdata,
    input  logic [LINK_W-1:0]   ram_rdata,
    output pfa_pkg::emit_t      emit
);

    localparam int STEP_W = $clog2(NUM_PAGES + 2);
    localparam int CNT_W  = $clog2(NUM_PAGES + 1);
    localparam int SUM_W  = STEP_W + 1;
    localparam int CMP_W  = STEP_W + 8;

    localparam logic [CMP_W-1:0]  N_C       = CMP_W'(NUM_PAGES);
    localparam logic [CMP_W-1:0]  MAX_C     = CMP_W'(MAX_ALLOC);
    localparam logic [SUM_W-1:0]  N_S       = SUM_W'(NUM_PAGES);
    localparam logic [STEP_W-1:0] N_STEP    = STEP_W'(NUM_PAGES);
    localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(NUM_PAGES - 1);
    localparam logic [CNT_W-1:0]  CNT_RST   = CNT_W'(NUM_PAGES);

    typedef enum logic [3:0] {
        S_INIT  = 4'b0001,
        S_IDLE  = 4'b0010,
        S_ALLOC = 4'b0100,
        S_FREE  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [PAGE_W-1:0]  init_reg, init_next;
    logic [PAGE_W-1:0]  node_reg, node_next;
    logic [PAGE_W-1:0]  head_reg, head_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [STEP_W-1:0]  count_reg, count_next;
    logic [PAGE_W-1:0]  free_head_reg, free_head_next;
    logic [CNT_W-1:0]   free_count_reg, free_count_next;

    logic [CMP_W-1:0]   req_x;
    logic [CMP_W-1:0]   avail_x;
    logic [CMP_W-1:0]   chead_x;
    logic [PAGE_W-1:0]  chead_pg;
    logic [PAGE_W-1:0]  link_r;
    logic               valid_r;
    // shared step unit: counter, compare, length sum
    logic [STEP_W-1:0]  step_inc;
    logic               step_hit;
    logic               step_in;
    logic [SUM_W-1:0]   sum;

    assign req_x    = CMP_W'(cmd.page_count);
    assign avail_x  = CMP_W'(free_count_reg);
    assign chead_x  = CMP_W'(cmd.chain_head);
    assign chead_pg = PAGE_W'(cmd.chain_head);
    assign link_r   = ram_rdata[PAGE_W-1:0];
    assign valid_r  = ram_rdata[PAGE_W];
    assign step_inc = step_reg + 1'b1;
    assign step_hit = (step_reg == count_reg);
    assign step_in  = (step_reg <= N_STEP);
    assign sum      = SUM_W'(free_count_reg) + SUM_W'(step_reg);

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        init_next       = init_reg;
        node_next       = node_reg;
        head_next       = head_reg;
        step_next       = step_reg;
        count_next      = count_reg;
        free_head_next  = free_head_reg;
        free_count_next = free_count_reg;
        ram_we          = 1'b0;
        ram_addr        = node_reg;
        ram_wdata       = '0;
        emit            = '0;

        case (state_reg)
            S_INIT:
            begin
                ram_we   = 1'b1;
                ram_addr = init_reg;
                if (init_reg == LAST_PAGE)
                begin
                    ram_wdata  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_wdata = {1'b1, PAGE_W'(init_reg + 1'b1)};
                    init_next = init_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    step_next = STEP_W'(1);
                    if (cmd.opcode == pfa_pkg::OP_ALLOC)
                    begin
                        if (cmd.page_count == '0)
                        begin
                            emit.valid       = 1'b1;
                            emit.word.last   = 1'b1;
                            emit.word.status = pfa_pkg::ST_EMPTY;
                        end
                        else if (req_x > avail_x || req_x > MAX_C)
                        begin
                            emit.valid       = 1'b1;
                            emit.word.last   = 1'b1;
                            emit.word.status = pfa_pkg::ST_SHORT;
                        end
                        else
                        begin
                            node_next  = free_head_reg;
                            ram_addr   = free_head_reg;
                            count_next = STEP_W'(cmd.page_count);
                            state_next = S_ALLOC;
                        end
                    end
                    else
                    begin
                        if (!cmd.chain_present)
                        begin
                            emit.valid       = 1'b1;
                            emit.word.last   = 1'b1;
                            emit.word.status = pfa_pkg::ST_EMPTY;
                        end
                        else if (chead_x >= N_C)
                        begin
                            emit.valid       = 1'b1;
                            emit.word.last   = 1'b1;
                            emit.word.status = pfa_pkg::ST_SHORT;
                        end
                        else
                        begin
                            node_next  = chead_pg;
                            head_next  = chead_pg;
                            ram_addr   = chead_pg;
                            state_next = S_FREE;
                        end
                    end
                end
            end
            S_ALLOC:
            begin
                // ram_rdata holds the link of node_reg
                emit.valid            = 1'b1;
                emit.word.frame_index = pfa_pkg::FRAME_W'(node_reg);
                emit.word.last        = step_hit;
                emit.word.status      = pfa_pkg::ST_OK;
                if (step_hit)
                begin
                    ram_we          = 1'b1;
                    ram_addr        = node_reg;
                    ram_wdata       = {1'b0, link_r};
                    free_head_next  = link_r;
                    free_count_next = free_count_reg - CNT_W'(count_reg);
                    state_next      = S_IDLE;
                end
                else
                begin
                    node_next = link_r;
                    ram_addr  = link_r;
                    step_next = step_inc;
                end
            end
            S_FREE:
            begin
                if (valid_r && step_in)
                begin
                    node_next = link_r;
                    ram_addr  = link_r;
                    step_next = step_inc;
                end
                else
                begin
                    emit.valid     = 1'b1;
                    emit.word.last = 1'b1;
                    state_next     = S_IDLE;
                    if (!step_in || sum > N_S)
                    begin
                        emit.word.status = pfa_pkg::ST_SHORT;
                    end
                    else
                    begin
                        emit.word.status = pfa_pkg::ST_OK;
                        ram_we           = 1'b1;
                        ram_addr         = node_reg;
                        ram_wdata        = {(free_count_reg != '0), free_head_reg};
                        free_head_next   = head_reg;
                        free_count_next  = CNT_W'(sum);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            init_reg       <= '0;
            free_head_reg  <= '0;
            free_count_reg <= CNT_RST;
        end
        else
        begin
            state_reg      <= state_next;
            init_reg       <= init_next;
            free_head_reg  <= free_head_next;
            free_count_reg <= free_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg  <= node_next;
        head_reg  <= head_next;
        step_reg  <= step_next;
        count_reg <= count_next;
    end

endmodule

/* src/page_frame_free_list_allocator.sv */
`timescale 1ns / 1ps

// Channel  | Ports                      | Handshake
// ---------+----------------------------+------------------------------------------
// command  | start, busy, cmd           | word taken at edge with start & !busy
// result   | result_valid, result       | one-cycle strobe, no backpressure
//
// Allocate of n frames: busy through the link walk, one frame word per cycle; the
// first word passes the state and output registers after accept, and the last one is
// shown in the cycle after busy drops. Free of a chain: busy through the tail search
// (bounded when no tail is found), one word shown in the cycle after busy drops.
// Rejected commands: busy stays low, one word shown in the cycle after accept.
// The rate is set by the single link-table port: one link read per cycle.
// After reset the block runs an init pass that builds the initial free chain in the
// link table; busy is high throughout.
// The receiver cannot stall; result words are shown for one cycle only.

module page_frame_free_list_allocator #(
    parameter int NUM_PAGES = pfa_pkg::NUM_PAGES_DEF,
    parameter int MAX_ALLOC = pfa_pkg::MAX_ALLOC_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  pfa_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             result_valid,
    output pfa_pkg::result_t result
);

    localparam int PAGE_W = $clog2(NUM_PAGES);
    // link table entry: {more-follows flag, next frame}
    localparam int LINK_W = PAGE_W + 1;

    logic              ram_we;
    logic [PAGE_W-1:0] ram_addr;
    logic [LINK_W-1:0] ram_wdata;
    logic [LINK_W-1:0] ram_rdata;
    pfa_pkg::emit_t    emit;

    logic              result_valid_reg;
    pfa_pkg::result_t  result_reg;

    // sequencer: init pass, head unlink walk, tail search walk
    pfa_seq #(
        .NUM_PAGES (NUM_PAGES),
        .MAX_ALLOC (MAX_ALLOC)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata),
        .emit      (emit)
    );

    // link table, one port, registered read
    pfa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NUM_PAGES)
    ) u_link (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // output register: strobe is cleared by reset, payload is not
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= emit.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            result_reg <= emit.word;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* src/pfa_checker.sv */
`timescale 1ns / 1ps

module pfa_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             result_valid,
    input pfa_pkg::result_t result
);

    // failed or empty results always close the command
    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != pfa_pkg::ST_OK |-> result.last)
        else $error("reject word without last");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != pfa_pkg::ST_OK |-> result.frame_index == '0)
        else $error("reject word with nonzero frame");

    // words only follow an accepted command or ongoing work
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy) || $past(start))
        else $error("result word with no command in flight");

    // mid-chain frame words come only from a running walk
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> $past(busy) && busy)
        else $error("non-last word outside a walk");

endmodule

bind page_frame_free_list_allocator pfa_checker u_pfa_checker (.*);

/* test/tb_page_frame_free_list_allocator.sv */
`timescale 1ns / 1ps

// Self-checking bench for the page frame allocator. A shadow copy of the link table
// predicts every result word at the moment a command word is accepted. Stimulus is a
// directed opener followed by random allocate/free traffic over several idle profiles.
module tb_page_frame_free_list_allocator;
    import pfa_pkg::*;

    localparam int NUM_PAGES = NUM_PAGES_DEF;
    localparam int MAX_ALLOC = MAX_ALLOC_DEF;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    cmd_t    cmd = '0;
    logic    busy;
    logic    result_valid;
    result_t result;

    page_frame_free_list_allocator #(
        .NUM_PAGES(NUM_PAGES),
        .MAX_ALLOC(MAX_ALLOC)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .cmd(cmd),
        .busy(busy),
        .result_valid(result_valid),
        .result(result)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow pool: next link and end-of-chain flag per frame, list head, free count
    // ------------------------------------------------------------------
    logic [FRAME_W-1:0] next_frame [NUM_PAGES];
    logic               link_live  [NUM_PAGES];
    logic [FRAME_W-1:0] head_frame;
    int                 frames_free;

    result_t            expected_words [$];   // result words still owed by the DUT
    cmd_t               pending_words  [$];   // command words not yet accepted
    logic [FRAME_W-1:0] allocated_heads [$];  // heads of chains handed out, for frees

    int issued = 0;
    int taken = 0;
    int offer_mark = -1;
    int idle_pct = 0;
    int errors = 0;
    int n_alloc = 0;
    int n_free = 0;
    int n_words = 0;
    int n_ok = 0;
    int n_short = 0;
    int n_empty = 0;
    int n_frames = 0;
    result_t want;

    function automatic void reset_pool();
        int i;
        for (i = 0; i < NUM_PAGES; i++)
        begin
            next_frame[i] = (i + 1 < NUM_PAGES) ? FRAME_W'(i + 1) : '0;
            link_live[i]  = (i + 1 < NUM_PAGES);
        end
        head_frame  = '0;
        frames_free = NUM_PAGES;
    endfunction

    function automatic void owe_word(logic [FRAME_W-1:0] frame, logic fin, logic [1:0] st);
        result_t w;
        w.frame_index = frame;
        w.last        = fin;
        w.status      = st;
        expected_words.push_back(w);
    endfunction

    // Applies one accepted command to the shadow pool and queues the words it owes
    function automatic void apply_command(cmd_t c);
        logic [FRAME_W-1:0] node;
        int                 len;
        int                 k;
        bit                 found;
        if (c.opcode == OP_ALLOC)
        begin
            if (c.page_count == 0)
                owe_word('0, 1'b1, ST_EMPTY);
            else if (c.page_count > frames_free || c.page_count > MAX_ALLOC)
                owe_word('0, 1'b1, ST_SHORT);
            else
            begin
                // Unlink from the head; the chain keeps its inner links, tail is cut
                allocated_heads.push_back(head_frame);
                node = head_frame;
                for (k = 1; k <= c.page_count; k++)
                begin
                    owe_word(node, k == c.page_count, ST_OK);
                    if (k == c.page_count)
                    begin
                        head_frame      = next_frame[node];
                        link_live[node] = 1'b0;
                    end
                    else
                        node = next_frame[node];
                end
                frames_free -= c.page_count;
            end
        end
        else if (!c.chain_present)
            owe_word('0, 1'b1, ST_EMPTY);
        else if (c.chain_head >= NUM_PAGES)
            owe_word('0, 1'b1, ST_SHORT);
        else
        begin
            // Bounded walk to the tail; a cyclic list never finds one
            node = c.chain_head;
            len  = 1;
            while (link_live[node] && len <= NUM_PAGES)
            begin
                node = next_frame[node];
                len++;
            end
            if (len > NUM_PAGES || frames_free + len > NUM_PAGES)
                owe_word('0, 1'b1, ST_SHORT);
            else
            begin
                next_frame[node] = head_frame;
                link_live[node]  = (frames_free > 0);
                head_frame       = c.chain_head;
                frames_free     += len;
                owe_word('0, 1'b1, ST_OK);
                found = 1'b0;
                for (k = 0; k < allocated_heads.size() && !found; k++)
                begin
                    if (allocated_heads[k] == c.chain_head)
                    begin
                        allocated_heads.delete(k);
                        found = 1'b1;
                    end
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: changes inputs on the falling edge. An offered word stays up until
    // taken; otherwise start may drop at a falling edge according to idle_pct.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!(start && taken == offer_mark))
        begin
            if (pending_words.size() == 0 || $urandom_range(0, 99) < idle_pct)
                start <= 1'b0;
            else
            begin
                start      <= 1'b1;
                cmd        <= pending_words[0];
                offer_mark  = taken;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: on the rising edge, records accepted command words into the
    // predictor and checks each result word against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            if (pending_words[0].opcode == OP_ALLOC)
                n_alloc++;
            else
                n_free++;
            apply_command(pending_words.pop_front());
            taken++;
        end
        if (rst_n && result_valid)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected result word: frame_index %0d last %0d status %0d",
                       result.frame_index, result.last, result.status);
                errors++;
            end
            else
            begin
                want = expected_words.pop_front();
                n_words++;
                if (want.status == ST_OK && want.frame_index != '0 || want.last == 1'b0)
                    n_frames += (want.status == ST_OK && !(want.last && want.frame_index == '0));
                case (want.status)
                    ST_OK:    n_ok++;
                    ST_SHORT: n_short++;
                    default:  n_empty++;
                endcase
                if (result.frame_index !== want.frame_index)
                begin
                    $error("frame_index: expected %0d, got %0d",
                           want.frame_index, result.frame_index);
                    errors++;
                end
                if (result.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, result.last);
                    errors++;
                end
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    errors++;
                end
            end
        end
    end

    // Queues one command word and returns once the DUT has taken it, so the
    // generator sees the pool as it stands after that word.
    task automatic issue(input cmd_t c);
        pending_words.push_back(c);
        issued++;
        wait (taken == issued);
    endtask

    // Unused fields get random bits so every input bit toggles
    task automatic request_frames(input int n);
        cmd_t c;
        c               = cmd_t'($urandom);
        c.opcode        = OP_ALLOC;
        c.page_count    = COUNT_W'(n);
        issue(c);
    endtask

    task automatic return_chain(input int head_idx, input logic present);
        cmd_t c;
        c               = cmd_t'($urandom);
        c.opcode        = OP_FREE;
        c.chain_head    = FRAME_W'(head_idx);
        c.chain_present = present;
        issue(c);
    endtask

    // Random traffic, mostly well-formed: allocations and frees of chains that
    // were handed out, with a few zero/oversize requests and stray frees.
    task automatic random_phase(input int pct, input int n);
        int r;
        int count;
        int pick;
        idle_pct = pct;
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                return_chain($urandom_range(0, NUM_PAGES - 1), 1'b0);
            else if (r < 5)
                return_chain($urandom_range(0, NUM_PAGES - 1), 1'b1);
            else if (allocated_heads.size() > 0 && (r < 48 || frames_free < 8))
            begin
                pick = $urandom_range(0, allocated_heads.size() - 1);
                return_chain(allocated_heads[pick], 1'b1);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    count = 0;
                else if (r < 8)
                    count = $urandom_range(MAX_ALLOC + 1, (1 << COUNT_W) - 1);
                else if (r < 14)
                    count = (frames_free < MAX_ALLOC) ? frames_free : MAX_ALLOC;
                else if (r < 18)
                    count = (frames_free < MAX_ALLOC) ? frames_free + 1 : MAX_ALLOC;
                else if (r < 28)
                    count = $urandom_range(9, MAX_ALLOC);
                else
                    count = $urandom_range(1, 8);
                request_frames(count);
            end
        end
    endtask

    initial
    begin
        reset_pool();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed opener; the DUT's init pass holds busy, the handshake waits it out
        idle_pct = 0;
        request_frames(0);              // empty request
        return_chain(0, 1'b0);          // free of an empty list
        request_frames(MAX_ALLOC + 1);  // over the per-request limit
        request_frames(127);            // largest count the field holds
        request_frames(1);              // single frame 0
        return_chain(0, 1'b1);          // back to a full pool
        return_chain(0, 1'b1);          // whole list too long to fit: rejected
        request_frames(MAX_ALLOC);      // frames 0..63
        request_frames(MAX_ALLOC);      // frames 64..127, pool now empty
        request_frames(1);              // nothing left
        return_chain(0, 1'b1);          // free into an empty list
        return_chain(0, 1'b1);          // double free closes the list into a loop
        return_chain(5, 1'b1);          // walk finds no tail
        request_frames(MAX_ALLOC);      // breaks the loop
        request_frames(MAX_ALLOC);      // same frames handed out again
        return_chain(64, 1'b1);
        return_chain(0, 1'b1);          // pool whole again
        return_chain(NUM_PAGES - 1, 1'b1);  // single-frame chain, pool already full
        request_frames(MAX_ALLOC);
        return_chain(0, 1'b1);

        // Idle profiles: none, sender 75%, none again (the receiver cannot stall), 12%
        random_phase(0, 115);
        random_phase(75, 115);
        random_phase(0, 115);
        random_phase(12, 115);

        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (2 * NUM_PAGES) @(posedge clk);

        $display("Ran %0d commands (%0d allocate, %0d free), checked %0d result words",
                 n_alloc + n_free, n_alloc, n_free, n_words);
        $display("Status mix: %0d ok, %0d short/rejected, %0d empty", n_ok, n_short, n_empty);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #(20_000_000);
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
src/pfa_pkg.sv
src/pfa_ram.sv
src/pfa_seq.sv
src/page_frame_free_list_allocator.sv
src/pfa_checker.sv
test/tb_page_frame_free_list_allocator.sv
